/* rtl/core/pidfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidfd_pkg
// Shared constants and register map of the filtered-derivative PID core.
// ----------------------------------------------------------------------------
package pidfd_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_PROP_GAIN      = 3'd0;
	localparam reg_idx_t REG_INTEG_COEFF    = 3'd1;
	localparam reg_idx_t REG_DERIV_GAIN     = 3'd2;
	localparam reg_idx_t REG_DERIV_FEEDBACK = 3'd3;
	localparam reg_idx_t REG_OUT_MIN        = 3'd4;
	localparam reg_idx_t REG_OUT_MAX        = 3'd5;
	localparam reg_idx_t REG_INTEG_MIN      = 3'd6;
	localparam reg_idx_t REG_INTEG_MAX      = 3'd7;

endpackage

/* rtl/core/pidfd_calc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidfd_calc
// Arithmetic of one control step, pipelined: error and differences, then the
// three products, then the integrator and derivative-filter recurrences, then
// the clamped output sum.
// ----------------------------------------------------------------------------
module pidfd_calc #(
	parameter int DATA_WIDTH = pidfd_pkg::DATA_WIDTH,
	parameter int FRAC_BITS  = pidfd_pkg::FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic                         valid_s1,
	input  logic signed [DATA_WIDTH-1:0] cfg [pidfd_pkg::NUM_REGS],
	input  logic signed [DATA_WIDTH-1:0] target,
	input  logic signed [DATA_WIDTH-1:0] measured,
	output logic                         valid_s4,
	output logic signed [DATA_WIDTH-1:0] prop_part,
	output logic signed [DATA_WIDTH-1:0] integ_part,
	output logic signed [DATA_WIDTH-1:0] deriv_part,
	output logic signed [DATA_WIDTH-1:0] drive
);

	localparam int W  = DATA_WIDTH;
	localparam int W1 = DATA_WIDTH + 1;
	localparam int W2 = 2 * DATA_WIDTH;
	localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	function automatic logic signed [W-1:0] sat_w(input logic signed [W:0] x);
		if (x[W] != x[W-1])
			return x[W] ? MINV : MAXV;
		return x[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		return sat_w(W1'(a) + W1'(b));
	endfunction

	function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		return sat_w(W1'(a) - W1'(b));
	endfunction

	function automatic logic signed [W-1:0] fx_mul(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic signed [W2-1:0] p;
		logic signed [W2-1:0] s;
		logic [W2-W:0] hi;
		p  = W2'(a) * W2'(b);
		s  = p >>> FRAC_BITS;
		hi = s[W2-1:W-1];
		if ((&hi) || !(|hi))
			return s[W-1:0];
		return p[W2-1] ? MINV : MAXV;
	endfunction

	function automatic logic signed [W-1:0] clamp(input logic signed [W-1:0] x,
			input logic signed [W-1:0] lo, input logic signed [W-1:0] hi);
		logic signed [W-1:0] t;
		t = (x < lo) ? lo : x;
		return (hi < t) ? hi : t;
	endfunction

	logic signed [W-1:0] last_error_q;
	logic signed [W-1:0] last_measured_q;
	logic signed [W-1:0] integ_acc_q;
	logic signed [W-1:0] deriv_acc_q;

	logic                valid_s2;
	logic                valid_s3;

	logic signed [W-1:0] error_c;
	logic signed [W-1:0] err_sum_c;
	logic signed [W-1:0] meas_diff_c;
	logic signed [W-1:0] error_s2;
	logic signed [W-1:0] err_sum_s2;
	logic signed [W-1:0] meas_diff_s2;

	logic signed [W-1:0] prop_c;
	logic signed [W-1:0] integ_inc_c;
	logic signed [W-1:0] deriv_gain_c;
	logic signed [W-1:0] prop_s3;
	logic signed [W-1:0] integ_inc_s3;
	logic signed [W-1:0] deriv_gain_s3;

	logic signed [W-1:0] integ_sum_c;
	logic signed [W-1:0] integ_c;
	logic signed [W-1:0] deriv_sum_c;
	logic signed [W-1:0] deriv_c;
	logic                integ_clamp_en;
	logic signed [W-1:0] prop_s4;

	// error and differences against the previous word
	always_comb begin
		error_c     = sat_sub(target, measured);
		err_sum_c   = sat_add(error_c, last_error_q);
		meas_diff_c = sat_sub(measured, last_measured_q);
	end

	// products outside the recurrences
	always_comb begin
		prop_c       = fx_mul(cfg[pidfd_pkg::REG_PROP_GAIN], error_s2);
		integ_inc_c  = fx_mul(cfg[pidfd_pkg::REG_INTEG_COEFF], err_sum_s2);
		deriv_gain_c = fx_mul(cfg[pidfd_pkg::REG_DERIV_GAIN], meas_diff_s2);
	end

	// integrator and derivative on measurement through the bilinear filter
	always_comb begin
		integ_sum_c    = sat_add(integ_acc_q, integ_inc_s3);
		integ_clamp_en = (cfg[pidfd_pkg::REG_INTEG_MIN] != '0)
			|| (cfg[pidfd_pkg::REG_INTEG_MAX] != '0);
		integ_c = integ_clamp_en
			? clamp(integ_sum_c, cfg[pidfd_pkg::REG_INTEG_MIN], cfg[pidfd_pkg::REG_INTEG_MAX])
			: integ_sum_c;
		deriv_sum_c = sat_add(deriv_gain_s3,
			fx_mul(cfg[pidfd_pkg::REG_DERIV_FEEDBACK], deriv_acc_q));
		deriv_c = sat_sub('0, deriv_sum_c);
	end

	// state holds the terms of the word in the last stage
	assign prop_part  = prop_s4;
	assign integ_part = integ_acc_q;
	assign deriv_part = deriv_acc_q;
	assign drive      = clamp(sat_add(sat_add(prop_s4, integ_acc_q), deriv_acc_q),
		cfg[pidfd_pkg::REG_OUT_MIN], cfg[pidfd_pkg::REG_OUT_MAX]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q    <= '0;
			last_measured_q <= '0;
		end else if (advance && valid_s1) begin
			last_error_q    <= error_c;
			last_measured_q <= measured;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			error_s2     <= error_c;
			err_sum_s2   <= err_sum_c;
			meas_diff_s2 <= meas_diff_c;
		end
		if (advance && valid_s2) begin
			prop_s3       <= prop_c;
			integ_inc_s3  <= integ_inc_c;
			deriv_gain_s3 <= deriv_gain_c;
		end
		if (advance && valid_s3) begin
			prop_s4 <= prop_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_acc_q <= '0;
			deriv_acc_q <= '0;
		end else if (advance && valid_s3) begin
			integ_acc_q <= integ_c;
			deriv_acc_q <= deriv_c;
		end
	end

endmodule

/* rtl/core/pid_controller_filtered_derivative_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_filtered_derivative_core
// Fixed-point PID controller with trapezoidal integrator and filtered
// derivative on the measurement, APB register port.
// ----------------------------------------------------------------------------
// The core takes one word (target, measured) per clock while the output is not
// stalled, and carries it to the result word (drive and the three terms) via
// the input register, a stage for the error and differences, a stage for the
// three products, a stage that closes the integrator and derivative-filter
// recurrences, then the output sum and clamp into the result register. The
// rate is set by the filter recurrence, whose multiply-add is combinational.
// A stalled result holds every stage; the input is stalled once the input
// register is also occupied. The user must write coefficients and clamps over
// APB only while the core is idle (not enforced); settings, flags and accumulators reset.
module pid_controller_filtered_derivative_core #(
	parameter int DATA_WIDTH = pidfd_pkg::DATA_WIDTH,
	parameter int FRAC_BITS  = pidfd_pkg::FRAC_BITS,
	localparam int BUS_W      = (DATA_WIDTH > 32) ? 64 : 32,
	localparam int STRIDE_LOG = (DATA_WIDTH > 32) ? 3 : 2,
	localparam int ADDR_W     = STRIDE_LOG + pidfd_pkg::REG_IDX_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ADDR_W-1:0]            paddr,
	input  logic [BUS_W-1:0]             pwdata,
	output logic [BUS_W-1:0]             prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] target,
	input  logic signed [DATA_WIDTH-1:0] measured,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] drive,
	output logic signed [DATA_WIDTH-1:0] prop_part,
	output logic signed [DATA_WIDTH-1:0] integ_part,
	output logic signed [DATA_WIDTH-1:0] deriv_part
);

	logic signed [DATA_WIDTH-1:0] cfg_q [pidfd_pkg::NUM_REGS];
	pidfd_pkg::reg_idx_t          reg_idx;

	logic                         valid_s1;
	logic signed [DATA_WIDTH-1:0] target_s1;
	logic signed [DATA_WIDTH-1:0] measured_s1;

	logic                         out_valid_q;
	logic signed [DATA_WIDTH-1:0] drive_q;
	logic signed [DATA_WIDTH-1:0] prop_q;
	logic signed [DATA_WIDTH-1:0] integ_q;
	logic signed [DATA_WIDTH-1:0] deriv_q;

	logic                         valid_c;
	logic signed [DATA_WIDTH-1:0] prop_c;
	logic signed [DATA_WIDTH-1:0] integ_c;
	logic signed [DATA_WIDTH-1:0] deriv_c;
	logic signed [DATA_WIDTH-1:0] drive_c;

	logic advance;
	logic fire;
	logic load_s1;

	// register port
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:STRIDE_LOG];
	assign prdata  = BUS_W'(cfg_q[reg_idx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pidfd_pkg::NUM_REGS; i++)
				cfg_q[i] <= '0;
		end else if (psel && penable && pwrite && pready) begin
			cfg_q[reg_idx] <= pwdata[DATA_WIDTH-1:0];
		end
	end

	// handshake
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_c && advance;
	assign load_s1  = !valid_s1 || advance;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			target_s1   <= target;
			measured_s1 <= measured;
		end
	end

	pidfd_calc #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_calc (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.cfg        (cfg_q),
		.target     (target_s1),
		.measured   (measured_s1),
		.valid_s4   (valid_c),
		.prop_part  (prop_c),
		.integ_part (integ_c),
		.deriv_part (deriv_c),
		.drive      (drive_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_c;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			drive_q <= drive_c;
			prop_q  <= prop_c;
			integ_q <= integ_c;
			deriv_q <= deriv_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign drive      = drive_q;
	assign prop_part  = prop_q;
	assign integ_part = integ_q;
	assign deriv_part = deriv_q;

endmodule

/* bench/pidfd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidfd_checker
// Watches the register port and both word channels of the PID core. Each
// register write goes into a local copy of the settings. Each accepted input
// word runs through a local model of the controller: the error, a trapezoidal
// integrator with optional clamp, a filtered derivative on the measurement
// and the clamped output, all saturating Q16.16. The expected terms wait in
// order, and every output word is compared field by field with the oldest.
// ----------------------------------------------------------------------------
module pidfd_checker
	import pidfd_pkg::*;
#(
	parameter int ADDR_W = 5,
	parameter int BUS_W  = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [ADDR_W-1:0]            paddr,
	input  logic [BUS_W-1:0]             pwdata,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] target,
	input  logic signed [DATA_WIDTH-1:0] measured,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic signed [DATA_WIDTH-1:0] drive,
	input  logic signed [DATA_WIDTH-1:0] prop_part,
	input  logic signed [DATA_WIDTH-1:0] integ_part,
	input  logic signed [DATA_WIDTH-1:0] deriv_part,
	output int                           mismatch_count,
	output int                           pending,
	output int                           checked_count
);

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] drive;
		logic signed [DATA_WIDTH-1:0] prop;
		logic signed [DATA_WIDTH-1:0] integ;
		logic signed [DATA_WIDTH-1:0] deriv;
	} pid_terms_t;

	localparam longint WORD_MAX = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
	localparam longint WORD_MIN = -WORD_MAX - 1;

	longint     coeff [NUM_REGS];
	longint     integ_acc;
	longint     prev_error;
	longint     prev_measured;
	longint     deriv_acc;
	pid_terms_t awaited [$];

	initial begin
		mismatch_count = 0;
		pending        = 0;
		checked_count  = 0;
	end

	function automatic longint sat_word(longint x);
		if (x > WORD_MAX)
			return WORD_MAX;
		if (x < WORD_MIN)
			return WORD_MIN;
		return x;
	endfunction

	// exact product, floor shift, then saturate
	function automatic longint fx_product(longint a, longint b);
		longint p;
		p = a * b;
		return sat_word(p >>> FRAC_BITS);
	endfunction

	// upper limit wins when the limits are inverted
	function automatic longint clamp_word(longint x, longint lo, longint hi);
		longint t;
		t = (x < lo) ? lo : x;
		return (hi < t) ? hi : t;
	endfunction

	function automatic pid_terms_t next_pid_terms(longint tgt, longint meas);
		pid_terms_t r;
		longint     err;
		longint     prop;
		longint     dsum;
		longint     drv;
		err  = sat_word(tgt - meas);
		prop = fx_product(coeff[REG_PROP_GAIN], err);
		integ_acc = sat_word(integ_acc +
			fx_product(coeff[REG_INTEG_COEFF], sat_word(err + prev_error)));
		if (coeff[REG_INTEG_MIN] != 0 || coeff[REG_INTEG_MAX] != 0)
			integ_acc = clamp_word(integ_acc, coeff[REG_INTEG_MIN], coeff[REG_INTEG_MAX]);
		dsum = sat_word(fx_product(coeff[REG_DERIV_GAIN], sat_word(meas - prev_measured)) +
			fx_product(coeff[REG_DERIV_FEEDBACK], deriv_acc));
		deriv_acc = sat_word(-dsum);
		drv = sat_word(sat_word(prop + integ_acc) + deriv_acc);
		drv = clamp_word(drv, coeff[REG_OUT_MIN], coeff[REG_OUT_MAX]);
		prev_error    = err;
		prev_measured = meas;
		r.drive = drv[DATA_WIDTH-1:0];
		r.prop  = prop[DATA_WIDTH-1:0];
		r.integ = integ_acc[DATA_WIDTH-1:0];
		r.deriv = deriv_acc[DATA_WIDTH-1:0];
		return r;
	endfunction

	function automatic int field_differs(string label, logic signed [DATA_WIDTH-1:0] want,
			logic signed [DATA_WIDTH-1:0] got);
		if (got === want)
			return 0;
		$display("%0t %s mismatch: expected %h, actual %h", $time, label, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pid_terms_t want;
		int         errs;
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				coeff[i] = 0;
			integ_acc     = 0;
			prev_error    = 0;
			prev_measured = 0;
			deriv_acc     = 0;
			awaited.delete();
			pending <= 0;
		end else begin
			errs = 0;
			if (psel && penable && pwrite && pready)
				coeff[paddr[ADDR_W-1:ADDR_W-REG_IDX_W]] = $signed(pwdata[DATA_WIDTH-1:0]);
			if (out_valid && !out_stall) begin
				checked_count <= checked_count + 1;
				if (awaited.size() == 0) begin
					$display("%0t unexpected output word: drive %h", $time, drive);
					errs = 1;
				end else begin
					want = awaited.pop_front();
					errs += field_differs("drive", want.drive, drive);
					errs += field_differs("prop_part", want.prop, prop_part);
					errs += field_differs("integ_part", want.integ, integ_part);
					errs += field_differs("deriv_part", want.deriv, deriv_part);
				end
			end
			if (in_valid && !in_stall)
				awaited.push_back(next_pid_terms(target, measured));
			mismatch_count <= mismatch_count + errs;
			pending <= awaited.size();
		end
	end

endmodule

/* bench/pid_controller_filtered_derivative_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_filtered_derivative_core_tb
// Drives the PID core through a short directed set of saturating and
// clamping cases, then phases of random settings, each followed by plant-like
// setpoint and measurement sequences mixed with full-range noise. Both
// channels idle at random; one phase holds the output back long enough to
// stall the input. A checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module pid_controller_filtered_derivative_core_tb;
	import pidfd_pkg::*;

	localparam int ADDR_W = 2 + REG_IDX_W;
	localparam int BUS_W  = 32;

	localparam logic signed [31:0] W_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] W_MIN = 32'sh80000000;
	localparam int                 ONE   = 32'sh00010000;

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         psel       = 1'b0;
	logic                         penable    = 1'b0;
	logic                         pwrite     = 1'b0;
	logic [ADDR_W-1:0]            paddr      = '0;
	logic [BUS_W-1:0]             pwdata     = '0;
	logic [BUS_W-1:0]             prdata;
	logic                         pready;
	logic                         in_valid   = 1'b0;
	logic                         in_stall;
	logic signed [DATA_WIDTH-1:0] target     = '0;
	logic signed [DATA_WIDTH-1:0] measured   = '0;
	logic                         out_valid;
	logic                         out_stall  = 1'b0;
	logic signed [DATA_WIDTH-1:0] drive;
	logic signed [DATA_WIDTH-1:0] prop_part;
	logic signed [DATA_WIDTH-1:0] integ_part;
	logic signed [DATA_WIDTH-1:0] deriv_part;

	int mismatch_count;
	int pending;
	int checked_count;

	bit tx_idle_on     = 1'b1;
	bit rx_idle_on     = 1'b1;
	int hold_requests  = 0;
	int holds_served   = 0;
	int sent_count     = 0;
	int settings_count = 0;

	always #1 clk = ~clk;

	pid_controller_filtered_derivative_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.target     (target),
		.measured   (measured),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.drive      (drive),
		.prop_part  (prop_part),
		.integ_part (integ_part),
		.deriv_part (deriv_part)
	);

	pidfd_checker #(.ADDR_W(ADDR_W), .BUS_W(BUS_W)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.target         (target),
		.measured       (measured),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.drive          (drive),
		.prop_part      (prop_part),
		.integ_part     (integ_part),
		.deriv_part     (deriv_part),
		.mismatch_count (mismatch_count),
		.pending        (pending),
		.checked_count  (checked_count)
	);

	initial begin
		#1_000_000;
		$display("timeout with %0d words outstanding", pending);
		$display("CHECKS FAILED");
		$finish;
	end

	// output side: random stall per word, one long hold-off on request
	initial begin : result_sink
		int stall_n;
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall_n = rx_idle_on ? $urandom_range(0, 12) : 0;
			if (hold_requests != holds_served) begin
				holds_served++;
				stall_n = 64;
			end
			if (stall_n > 0) begin
				out_stall <= 1'b1;
				repeat (stall_n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	function automatic int near(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(0, 9))
			0: return W_MAX;
			1: return W_MIN;
			2: return '0;
			3: return $urandom();
			default: return near(4 * ONE);
		endcase
	endfunction

	function automatic logic [31:0] extreme_value();
		case ($urandom_range(0, 3))
			0: return W_MAX;
			1: return W_MIN;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	task automatic pick_limits(input bit allow_open, output logic [31:0] lo, output logic [31:0] hi);
		int a;
		int b;
		a = near(200 * ONE);
		b = near(200 * ONE);
		case ($urandom_range(0, 4))
			0: begin
				lo = allow_open ? '0 : W_MIN;
				hi = allow_open ? '0 : W_MAX;
			end
			1: begin
				lo = (a < b) ? a : b;
				hi = (a < b) ? b : a;
			end
			2: begin
				lo = (a < b) ? b : a;
				hi = (a < b) ? a : b;
			end
			3: begin
				lo = $urandom();
				hi = $urandom();
			end
			default: begin
				lo = $urandom_range(0, 1) ? '0 : -$urandom_range(1, 50 * ONE);
				hi = (lo == 0) ? $urandom_range(1, 50 * ONE) : '0;
			end
		endcase
	endtask

	task automatic load_settings(input logic [31:0] pg, ic, dg, df, omin, omax, imin, imax);
		logic [31:0] vals [NUM_REGS];
		int          i;
		vals[REG_PROP_GAIN]      = pg;
		vals[REG_INTEG_COEFF]    = ic;
		vals[REG_DERIV_GAIN]     = dg;
		vals[REG_DERIV_FEEDBACK] = df;
		vals[REG_OUT_MIN]        = omin;
		vals[REG_OUT_MAX]        = omax;
		vals[REG_INTEG_MIN]      = imin;
		vals[REG_INTEG_MAX]      = imax;
		for (i = 0; i < NUM_REGS; i++) begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= ADDR_W'(i << 2);
			pwdata  <= vals[i];
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready)
				@(posedge clk);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		settings_count++;
	endtask

	task automatic send_sample(input logic signed [31:0] tgt, input logic signed [31:0] meas);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		target   <= tgt;
		measured <= meas;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_count++;
	endtask

	task automatic await_drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	initial begin : stimulus
		logic [31:0] omin;
		logic [31:0] omax;
		logic [31:0] imin;
		logic [31:0] imax;
		int          tgt_level;
		int          meas_level;
		int          ph;
		int          k;
		int          r;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero gains, closed output clamp, open integrator
		send_sample(W_MAX, W_MIN);
		send_sample(W_MIN, W_MAX);
		send_sample(0, -1);
		await_drain();

		// extreme gains, saturating error and derivative, negated minimum
		load_settings(W_MAX, W_MIN, W_MAX, W_MIN, W_MIN, W_MAX, 0, 0);
		send_sample(W_MAX, W_MIN);
		send_sample(W_MIN, W_MAX);
		send_sample(0, W_MAX);
		send_sample(0, W_MIN);
		send_sample(-1, -1);
		send_sample(1, 0);
		send_sample(ONE, -ONE);
		await_drain();

		// inverted output and integrator limits
		load_settings(2 * ONE, ONE / 4, ONE / 2, ONE / 2, 10 * ONE, -10 * ONE,
			3 * ONE, -3 * ONE);
		send_sample(5 * ONE, 0);
		send_sample(-5 * ONE, ONE);
		send_sample(0, 0);
		send_sample(W_MAX, W_MIN);
		await_drain();

		// integrator clamp active with one limit zero
		load_settings(ONE, ONE, ONE, -ONE / 2, W_MIN, W_MAX, 0, 2 * ONE);
		repeat (3) send_sample(4 * ONE, 0);
		repeat (2) send_sample(-4 * ONE, 0);
		await_drain();

		for (ph = 0; ph < 8; ph++) begin
			pick_limits(1'b0, omin, omax);
			pick_limits(1'b1, imin, imax);
			load_settings(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
				omin, omax, imin, imax);
			tx_idle_on = (ph != 0) && ($urandom_range(0, 3) != 0);
			rx_idle_on = (ph != 0) && ($urandom_range(0, 3) != 0);
			if (ph == 4) begin
				tx_idle_on = 1'b0;
				hold_requests++;
			end
			tgt_level  = near(50 * ONE);
			meas_level = near(50 * ONE);
			for (k = 0; k < 200; k++) begin
				r = $urandom_range(0, 9);
				if (r < 7) begin
					if ($urandom_range(0, 19) == 0)
						tgt_level = near(50 * ONE);
					meas_level = meas_level + (tgt_level - meas_level) / 8 + near(ONE / 4);
					send_sample(tgt_level, meas_level);
				end else if (r < 9) begin
					send_sample($urandom(), $urandom());
				end else begin
					send_sample(extreme_value(), extreme_value());
				end
			end
			await_drain();
		end

		repeat (16) @(posedge clk);
		$display("run covered %0d samples under %0d register settings, %0d words compared",
			sent_count, settings_count, checked_count);
		$display("limits open, ordered and inverted; saturating extremes; output hold-off");
		if (mismatch_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d words outstanding", mismatch_count, pending);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
